// ===== hw/rtl/fwnp_pkg.sv =====
// Package for the FIFO with negative purge: sizes, command codes, state type
// and the structs passed between the controller, the cells and the top level.
// No dependencies.
`default_nettype none

package fwnp_pkg;

    // Queue geometry
    localparam int DEPTH  = 16;
    localparam int DATA_W = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // Stream packing
    localparam int CMD_W       = 2;
    localparam int S_FIELDS_W  = CMD_W + DATA_W;
    localparam int S_TDATA_W   = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W  = DATA_W + 2 + CNT_W;
    localparam int M_TDATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    // Command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_PURGE   = 2'd2
    } cmd_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_PURGE
    } state_t;

    // Control to the row of cells
    typedef struct packed {
        logic             shift;    // every cell takes its upper neighbour's entry
        logic             wr_en;    // load one cell with wr_data
        logic [IDX_W-1:0] wr_idx;
        logic [DATA_W-1:0] wr_data;
    } cell_ctrl_t;

    // One finished result item
    typedef struct packed {
        logic              valid;
        logic [DATA_W-1:0] read_value;
        logic              empty_error;
        logic              full_error;
        logic [CNT_W-1:0]  entry_count;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fifo_with_negative_purge.sv =====
// Top level of the FIFO with negative purge: row of storage cells, controller
// and output register. Depends on fwnp_pkg, fwnp_cell and fwnp_ctrl.
//
// Usage:
//   s_ channel carries one command item: enqueue a value, dequeue the oldest
//   entry, or purge every negative entry. m_ channel returns exactly one
//   result item per command with the dequeued value, the empty and full
//   error flags and the entry count after the command.
//   Entries live in a row of DEPTH cells, oldest in cell 0. A dequeue shifts
//   the whole row down by one; an enqueue loads the cell at the tail.
//   For enqueue, dequeue, unused codes and a purge of an empty queue the
//   result is registered and shows on m_ the cycle after accept.
//   A purge of N entries makes one cell shift per entry, the head
//   being re-loaded at the tail when it is not negative; its result appears
//   after the last step. s_tready is low while a purge runs.
//   Throughput is one item per cycle for enqueue and dequeue while m_tready
//   stays high.
//   When the receiver stalls, the result holds in the output register and
//   a new item is taken only once it has been accepted.
//   Synchronous reset empties the queue and drops any pending result.
`default_nettype none

module fifo_with_negative_purge (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // [1:0] command, [33:2] value, rest zero
    input  wire logic [fwnp_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // [31:0] read_value, [32] empty_error, [33] full_error, [38:34] entry_count
    output logic      [fwnp_pkg::M_TDATA_W-1:0] m_tdata
);
    import fwnp_pkg::*;

    cell_ctrl_t        cell_ctrl;
    result_t           result;
    logic [DATA_W-1:0] cell_data [DEPTH];
    logic              out_free;

    logic              m_tvalid_reg;
    logic [M_FIELDS_W-1:0] m_fields_reg;

    assign out_free = !m_tvalid_reg || m_tready;

    fwnp_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_cmd    (s_tdata[CMD_W-1:0]),
        .in_value  (s_tdata[S_FIELDS_W-1:CMD_W]),
        .out_free  (out_free),
        .head_data (cell_data[0]),
        .in_ready  (s_tready),
        .cell_ctrl (cell_ctrl),
        .result    (result)
    );

    // Row of cells, each fed by its upper neighbour
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [DATA_W-1:0] upper;
        logic              load;

        if (i < DEPTH - 1) begin : g_mid
            assign upper = cell_data[i+1];
        end else begin : g_top
            assign upper = '0;
        end

        assign load = cell_ctrl.wr_en && (cell_ctrl.wr_idx == IDX_W'(i));

        fwnp_cell u_cell (
            .aclk       (aclk),
            .shift      (cell_ctrl.shift),
            .load       (load),
            .load_data  (cell_ctrl.wr_data),
            .upper_data (upper),
            .data       (cell_data[i])
        );
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (result.valid) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result.valid) begin
            m_fields_reg <= {result.entry_count, result.full_error,
                             result.empty_error, result.read_value};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'(m_fields_reg);

    // Checks
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[M_FIELDS_W-1:DATA_W+2] <= CNT_W'(DEPTH)))
        else $error("entry count above depth");

    a_one_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[DATA_W] && m_tdata[DATA_W+1]))
        else $error("empty and full error together");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[DATA_W]) |-> (m_tdata[DATA_W-1:0] == '0))
        else $error("empty dequeue with non-zero value");

    a_no_accept_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input taken while result stalled");

endmodule

`default_nettype wire

// ===== hw/rtl/fwnp_cell.sv =====
// One storage cell of the queue row: holds a single entry and either keeps
// it, takes its upper neighbour's entry on a shift, or loads a new value.
// Depends on fwnp_pkg.
`default_nettype none

module fwnp_cell (
    input  wire logic                       aclk,
    input  wire logic                       shift,
    input  wire logic                       load,
    input  wire logic [fwnp_pkg::DATA_W-1:0] load_data,
    input  wire logic [fwnp_pkg::DATA_W-1:0] upper_data,
    output logic      [fwnp_pkg::DATA_W-1:0] data
);
    import fwnp_pkg::*;

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // load wins over shift: during a purge the kept entry lands at the tail
    always_comb begin
        if (load) begin
            data_next = load_data;
        end else if (shift) begin
            data_next = upper_data;
        end else begin
            data_next = data_reg;
        end
    end

    // payload only, no reset
    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/fwnp_ctrl.sv =====
// Queue controller: entry count, purge sequencer and result generation.
// Drives the cell row through a cell_ctrl_t struct. Depends on fwnp_pkg.
`default_nettype none

module fwnp_ctrl (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        in_valid,
    input  wire logic [fwnp_pkg::CMD_W-1:0]  in_cmd,
    input  wire logic [fwnp_pkg::DATA_W-1:0] in_value,
    input  wire logic                        out_free,
    input  wire logic [fwnp_pkg::DATA_W-1:0] head_data,
    output logic                             in_ready,
    output fwnp_pkg::cell_ctrl_t             cell_ctrl,
    output fwnp_pkg::result_t                result
);
    import fwnp_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] remain_reg, remain_next;
    logic             accept;
    logic             keep;
    logic [CNT_W-1:0] tail_idx;

    assign in_ready = (state_reg == ST_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign keep     = ~head_data[DATA_W-1];
    assign tail_idx = count_reg - CNT_W'(1);

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (cmd_t'(in_cmd) == CMD_PURGE) && (count_reg != '0)) begin
                    state_next = ST_PURGE;
                end
            end
            ST_PURGE: begin
                if (remain_reg == CNT_W'(1)) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        cell_ctrl   = '0;
        result      = '0;
        count_next  = count_reg;
        remain_next = remain_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    result.valid = 1'b1;
                    case (cmd_t'(in_cmd))
                        CMD_ENQUEUE: begin
                            if (count_reg == CNT_W'(DEPTH)) begin
                                result.full_error = 1'b1;
                            end else begin
                                cell_ctrl.wr_en   = 1'b1;
                                cell_ctrl.wr_idx  = count_reg[IDX_W-1:0];
                                cell_ctrl.wr_data = in_value;
                                count_next        = count_reg + CNT_W'(1);
                            end
                        end
                        CMD_DEQUEUE: begin
                            if (count_reg == '0) begin
                                result.empty_error = 1'b1;
                            end else begin
                                cell_ctrl.shift   = 1'b1;
                                result.read_value = head_data;
                                count_next        = count_reg - CNT_W'(1);
                            end
                        end
                        CMD_PURGE: begin
                            // empty queue: nothing to scan, answer at once
                            if (count_reg != '0) begin
                                result.valid = 1'b0;
                                remain_next  = count_reg;
                            end
                        end
                        default: ;
                    endcase
                    result.entry_count = count_next;
                end
            end
            ST_PURGE: begin
                // pop the head; a non-negative entry goes straight back at the tail
                cell_ctrl.shift = 1'b1;
                if (keep) begin
                    cell_ctrl.wr_en   = 1'b1;
                    cell_ctrl.wr_idx  = tail_idx[IDX_W-1:0];
                    cell_ctrl.wr_data = head_data;
                end else begin
                    count_next = count_reg - CNT_W'(1);
                end
                remain_next = remain_reg - CNT_W'(1);
                if (remain_reg == CNT_W'(1)) begin
                    result.valid       = 1'b1;
                    result.entry_count = count_next;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
        end else begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/tb_fifo_with_negative_purge.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fifo_with_negative_purge: directed corner items, then
// random enqueue/dequeue/purge traffic, with some unused codes, and idle gaps on both stream sides.
// Depends on fwnp_pkg and the fifo_with_negative_purge RTL.

module tb_fifo_with_negative_purge;

    import fwnp_pkg::*;

    // Command code with no operation behind it
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 550;
    localparam int SETTLE_CYCLES = 2 * DEPTH + 8;

    typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

    // Expected fields of one result item
    typedef struct {
        logic [DATA_W-1:0] read_value;
        logic              empty_error;
        logic              full_error;
        logic [CNT_W-1:0]  entry_count;
    } queue_result_t;

    // Mirror of the queue contents plus the results still owed by the block
    class fifo_mirror;
        logic [DATA_W-1:0] held_values[$];
        queue_result_t     awaited_results[$];
        int mismatches;
        int results_seen;
        int full_hits;
        int empty_hits;
        int purged_entries;
        int per_command[4];

        // Apply one accepted command to the mirror and queue its expected result
        function void note_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
            queue_result_t r;
            logic [DATA_W-1:0] kept[$];
            r.read_value  = '0;
            r.empty_error = 1'b0;
            r.full_error  = 1'b0;
            per_command[cmd]++;
            case (cmd)
                CMD_ENQUEUE: begin
                    if (held_values.size() >= DEPTH) begin
                        r.full_error = 1'b1;
                        full_hits++;
                    end else begin
                        held_values.push_back(value);
                    end
                end
                CMD_DEQUEUE: begin
                    if (held_values.size() == 0) begin
                        r.empty_error = 1'b1;
                        empty_hits++;
                    end else begin
                        r.read_value = held_values.pop_front();
                    end
                end
                CMD_PURGE: begin
                    // keep non-negative entries in their original order
                    foreach (held_values[i])
                        if (!held_values[i][DATA_W-1])
                            kept.push_back(held_values[i]);
                    purged_entries += held_values.size() - kept.size();
                    held_values = kept;
                end
                default: ;
            endcase
            r.entry_count = CNT_W'(held_values.size());
            awaited_results.push_back(r);
        endfunction

        // Compare one accepted result item with the oldest expectation
        function void check_result(logic [M_TDATA_W-1:0] word);
            queue_result_t e;
            logic [DATA_W-1:0] got_value;
            logic              got_empty;
            logic              got_full;
            logic [CNT_W-1:0]  got_count;
            got_value = word[DATA_W-1:0];
            got_empty = word[DATA_W];
            got_full  = word[DATA_W+1];
            got_count = word[DATA_W+2 +: CNT_W];
            results_seen++;
            if (awaited_results.size() == 0) begin
                $display("%0t: result item with nothing expected, tdata %h", $time, word);
                mismatches++;
                return;
            end
            e = awaited_results.pop_front();
            if (got_value !== e.read_value) begin
                $display("%0t: read_value expected %h actual %h",
                         $time, e.read_value, got_value);
                mismatches++;
            end
            if (got_empty !== e.empty_error) begin
                $display("%0t: empty_error expected %b actual %b",
                         $time, e.empty_error, got_empty);
                mismatches++;
            end
            if (got_full !== e.full_error) begin
                $display("%0t: full_error expected %b actual %b",
                         $time, e.full_error, got_full);
                mismatches++;
            end
            if (got_count !== e.entry_count) begin
                $display("%0t: entry_count expected %0d actual %0d",
                         $time, e.entry_count, got_count);
                mismatches++;
            end
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // no gaps on either side while set
    bit calm = 1'b0;
    int stall_left = 0;

    fifo_mirror mirror = new;

    fifo_with_negative_purge dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 2);
        if (r < 97)
            return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // Drive one command item and wait for it to be taken
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, value, cmd};
        do
            @(posedge aclk);
        while (!s_tready);
        mirror.note_command(cmd, value);
    endtask

    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        int r;
        r = $urandom_range(0, 99);
        v = $urandom();
        case ($urandom_range(0, 4))
            0: v = 32'h8000_0000;
            1: v = 32'h7FFF_FFFF;
            2: v = '0;
            3: v = '1;
            default: v = 32'h0000_0001;
        endcase
        if (r >= 10) begin
            v = $urandom();
            // roughly half negative so purges have work to do
            if (r < 55)
                v[DATA_W-1] = 1'b1;
            else if (r < 90)
                v[DATA_W-1] = 1'b0;
        end
        return v;
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(mix_t mix);
        int r;
        int enq_share;
        r = $urandom_range(0, 99);
        if (r < 2)
            return CMD_UNUSED;
        if (r < 10)
            return CMD_PURGE;
        enq_share = (mix == MIX_FILL) ? 75 : (mix == MIX_DRAIN) ? 35 : 55;
        return (r < enq_share) ? CMD_ENQUEUE : CMD_DEQUEUE;
    endfunction

    // Result side: check accepted items, then choose the next ready level
    always @(posedge aclk) begin
        int n;
        if (aresetn && m_tvalid && m_tready)
            mirror.check_result(m_tdata);
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            n = pick_gap();
            if (n > 0) begin
                m_tready <= 1'b0;
                stall_left = n - 1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Stimulus and end of run
    initial begin
        mix_t mix;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty queue corners, unused code, value extremes
        send_item(CMD_DEQUEUE, 32'hDEAD_BEEF);
        send_item(CMD_PURGE, 32'h1234_5678);
        send_item(CMD_UNUSED, 32'hFFFF_FFFF);
        send_item(CMD_ENQUEUE, 32'h8000_0000);
        send_item(CMD_ENQUEUE, 32'h7FFF_FFFF);
        send_item(CMD_ENQUEUE, 32'h0000_0000);
        send_item(CMD_ENQUEUE, 32'hFFFF_FFFF);
        send_item(CMD_ENQUEUE, 32'h0000_0001);
        // purge keeps the three non-negative entries
        send_item(CMD_PURGE, '0);
        // fill to the brim, then one enqueue too many
        for (int i = 0; i < DEPTH - 3; i++)
            send_item(CMD_ENQUEUE, (i % 2) ? $urandom() | 32'h8000_0000 : $urandom() >> 1);
        send_item(CMD_ENQUEUE, 32'h5555_5555);
        send_item(CMD_UNUSED, 32'h0);
        send_item(CMD_PURGE, 32'hAAAA_AAAA);
        send_item(CMD_DEQUEUE, '0);

        // Random traffic in phases that lean towards full, empty or neither
        mix = MIX_EVEN;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 50 == 0) begin
                mix  = mix_t'($urandom_range(0, 2));
                calm = ($urandom_range(0, 3) == 0);
            end
            send_item(pick_command(mix), pick_value());
        end
        s_tvalid <= 1'b0;
        calm = 1'b0;

        while (mirror.pending() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run covered %0d enqueues, %0d dequeues, %0d purges, %0d unused codes;",
                 mirror.per_command[CMD_ENQUEUE], mirror.per_command[CMD_DEQUEUE],
                 mirror.per_command[CMD_PURGE], mirror.per_command[CMD_UNUSED]);
        $display("%0d results checked, %0d full drops, %0d empty reads, %0d entries purged.",
                 mirror.results_seen, mirror.full_hits, mirror.empty_hits,
                 mirror.purged_entries);
        if (mirror.mismatches == 0 && mirror.pending() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Timeout: %0d result items still expected", mirror.pending());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
